// File: src/hpq_pkg.sv
// Shared types, constants and helpers for the height plateau qualifier.
package hpq_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int LEVEL_BITS  = SAMPLE_BITS + 1;
  localparam int DIFF_BITS   = SAMPLE_BITS + 2;
  localparam int THRESH_BITS = 12;
  localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_BITS    = THRESH_BITS;

  typedef logic [SAMPLE_BITS-1:0]        sample_t;
  typedef logic signed [LEVEL_BITS-1:0]  level_t;
  typedef logic [THRESH_BITS-1:0]        thresh_t;
  typedef logic [TDATA_BITS-1:0]         tdata_t;
  typedef logic [CFG_BITS-1:0]           cfg_data_t;

  // Register indexes of the configuration port
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_STATION   = 1'b1;

  // Event kinds
  localparam logic KIND_HEIGHT = 1'b0;
  localparam logic KIND_ENDED  = 1'b1;

  // No level confirmed yet
  localparam level_t NO_LEVEL = '1;

  typedef struct packed {
    logic    baseline_valid;
    sample_t baseline_level;
    level_t  confirmed_level;
    sample_t candidate_level;
    logic    candidate_pending;
    logic    report_pending;
  } state_t;

  typedef struct packed {
    logic emit;
    logic kind;
  } event_t;

  // True when |a - b| <= thr
  function automatic logic near_enough(input level_t a, input level_t b, input thresh_t thr);
    logic signed [DIFF_BITS-1:0] diff;
    logic [DIFF_BITS-1:0]        mag;
    diff = DIFF_BITS'(a) - DIFF_BITS'(b);
    mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
    return mag <= DIFF_BITS'(thr);
  endfunction

endpackage

// File: src/hpq_decide.sv
// Per-sample decision: baseline, plateau and candidate checks with next state.
module hpq_decide (
  input  hpq_pkg::sample_t sample,
  input  hpq_pkg::state_t  state,
  input  hpq_pkg::thresh_t threshold,
  output hpq_pkg::state_t  state_nxt,
  output hpq_pkg::event_t  evt
);

  hpq_pkg::sample_t base;
  hpq_pkg::level_t  s_lvl;
  logic             near_base;
  logic             near_conf;
  logic             near_cand;

  always_comb begin
    base      = state.baseline_valid ? state.baseline_level : sample;
    s_lvl     = hpq_pkg::level_t'({1'b0, sample});
    near_base = hpq_pkg::near_enough(s_lvl, hpq_pkg::level_t'({1'b0, base}), threshold);
    near_conf = hpq_pkg::near_enough(s_lvl, state.confirmed_level, threshold);
    near_cand = hpq_pkg::near_enough(s_lvl, hpq_pkg::level_t'({1'b0, state.candidate_level}),
                                     threshold);

    state_nxt                = state;
    state_nxt.baseline_valid = 1'b1;
    state_nxt.baseline_level = base;
    evt.emit                 = 1'b0;
    evt.kind                 = hpq_pkg::KIND_HEIGHT;

    if (near_base) begin
      // back at the belt: drop candidate, close an open plateau
      state_nxt.candidate_pending = 1'b0;
      if (state.report_pending) begin
        evt.emit                 = 1'b1;
        evt.kind                 = hpq_pkg::KIND_ENDED;
        state_nxt.report_pending = 1'b0;
      end
    end else if (near_conf) begin
      evt.emit                 = 1'b1;
      evt.kind                 = hpq_pkg::KIND_HEIGHT;
      state_nxt.report_pending = 1'b1;
    end else if (!state.candidate_pending) begin
      state_nxt.candidate_pending = 1'b1;
      state_nxt.candidate_level   = sample;
    end else if (near_cand) begin
      state_nxt.confirmed_level   = s_lvl;
      state_nxt.candidate_pending = 1'b0;
    end else begin
      state_nxt.candidate_pending = 1'b0;
    end
  end

endmodule

// File: src/height_plateau_qualifier_unit.sv
// Top level of the height plateau qualifier: ports, registers and handshakes.
// One converter sample per item enters on the in_ stream; at most one event per
// item leaves on the out_ stream. The very first sample after reset becomes the
// belt baseline. Samples close to the baseline drop any candidate level and,
// when a plateau was being reported, give a "plateau ended" event. Samples close
// to the confirmed level give a height event. Other samples feed a two-sample
// candidate check that confirms a new level. An accepted sample is loaded into the
// input register; the decision logic loads its event into the result register
// when the result slot is free, and the event is offered from there. An item is
// accepted every cycle while the result side keeps taking events; the state update
// of one item is done in the same cycle that loads its result, so the next item
// sees it at once. The configuration port is always ready and must only be
// written while no item is in flight.
module height_plateau_qualifier_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  hpq_pkg::tdata_t        in_tdata,   // [11:0] sample, rest zero
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output hpq_pkg::tdata_t        out_tdata,  // [11:0] height_value, rest zero
  output logic [1:0]             out_tuser,  // [0] event_kind, [1] station_tag
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  hpq_pkg::cfg_data_t     cfg_data
);

  hpq_pkg::thresh_t threshold_r, threshold_nxt;
  logic             station_r, station_nxt;

  logic             s_valid_r, s_valid_nxt;
  hpq_pkg::sample_t s_sample_r, s_sample_nxt;

  hpq_pkg::state_t  state_r, state_nxt, state_calc;
  hpq_pkg::event_t  evt;

  logic             o_valid_r, o_valid_nxt;
  logic             o_kind_r, o_kind_nxt;
  logic             o_station_r, o_station_nxt;
  hpq_pkg::sample_t o_height_r, o_height_nxt;

  logic             advance;

  hpq_decide u_decide (
    .sample    (s_sample_r),
    .state     (state_r),
    .threshold (threshold_r),
    .state_nxt (state_calc),
    .evt       (evt)
  );

  // The result slot is free when empty or being taken this cycle
  assign advance   = !o_valid_r || out_tready;
  assign in_tready = !s_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = o_valid_r;
  assign out_tdata  = hpq_pkg::tdata_t'(o_height_r);
  assign out_tuser  = {o_station_r, o_kind_r};

  // Configuration decode
  always_comb begin
    threshold_nxt = threshold_r;
    station_nxt   = station_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        hpq_pkg::REG_THRESHOLD: threshold_nxt = hpq_pkg::thresh_t'(cfg_data);
        hpq_pkg::REG_STATION:   station_nxt   = cfg_data[0];
        default:                threshold_nxt = threshold_r;
      endcase
    end
  end

  // Input register: hold while the decision stage is stalled
  always_comb begin
    s_valid_nxt  = s_valid_r;
    s_sample_nxt = s_sample_r;
    if (in_tready) begin
      s_valid_nxt = in_tvalid;
      if (in_tvalid) begin
        s_sample_nxt = in_tdata[hpq_pkg::SAMPLE_BITS-1:0];
      end
    end
  end

  // Decision stage: commit state and load the result slot together
  always_comb begin
    state_nxt     = state_r;
    o_valid_nxt   = o_valid_r;
    o_kind_nxt    = o_kind_r;
    o_station_nxt = o_station_r;
    o_height_nxt  = o_height_r;
    if (advance) begin
      o_valid_nxt = s_valid_r && evt.emit;
      if (s_valid_r) begin
        state_nxt = state_calc;
        if (evt.emit) begin
          o_kind_nxt    = evt.kind;
          o_station_nxt = station_r;
          o_height_nxt  = s_sample_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r                 <= hpq_pkg::thresh_t'(50);
      station_r                   <= 1'b0;
      s_valid_r                   <= 1'b0;
      o_valid_r                   <= 1'b0;
      state_r.baseline_valid      <= 1'b0;
      state_r.baseline_level      <= '0;
      state_r.confirmed_level     <= hpq_pkg::NO_LEVEL;
      state_r.candidate_level     <= '0;
      state_r.candidate_pending   <= 1'b0;
      state_r.report_pending      <= 1'b0;
    end else begin
      threshold_r <= threshold_nxt;
      station_r   <= station_nxt;
      s_valid_r   <= s_valid_nxt;
      o_valid_r   <= o_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    s_sample_r  <= s_sample_nxt;
    o_kind_r    <= o_kind_nxt;
    o_station_r <= o_station_nxt;
    o_height_r  <= o_height_nxt;
  end

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the height plateau qualifier: directed and random samples.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SAMPLE   = 4095;
  localparam int BELT_SAMPLE  = 2000;   // first sample of the run, becomes the baseline
  localparam int DRAIN_CYCLES = 6;      // input and result registers plus margin
  localparam int LONG_STALL   = 120;    // receiver hold-off under pressure, in cycles

  typedef struct {
    logic             kind;
    logic             tag;
    hpq_pkg::sample_t value;
  } plateau_event_t;

  // DUT ports, all inputs known from time zero
  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  hpq_pkg::tdata_t    in_tdata   = '0;    // [11:0] sample, rest zero
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  hpq_pkg::tdata_t    out_tdata;          // [11:0] height_value, rest zero
  logic [1:0]         out_tuser;          // [0] event_kind, [1] station_tag
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic               cfg_index  = hpq_pkg::REG_THRESHOLD;
  hpq_pkg::cfg_data_t cfg_data   = '0;

  // Predicted copy of the registers and the qualifier state
  hpq_pkg::thresh_t model_threshold = 12'd50;
  logic             model_station   = 1'b0;
  logic             have_baseline   = 1'b0;
  hpq_pkg::sample_t belt_baseline   = '0;
  hpq_pkg::level_t  plateau_level   = hpq_pkg::NO_LEVEL;
  hpq_pkg::sample_t candidate       = '0;
  logic             candidate_armed = 1'b0;
  logic             end_armed       = 1'b0;

  plateau_event_t pending_events[$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int events_checked = 0;
  int reg_writes     = 0;
  int sender_gap_pct = 0;
  int sink_stall_pct = 0;
  int stall_requests = 0;

  height_plateau_qualifier_unit i_dut (
    .clk,
    .rst_n,
    .in_tvalid,
    .in_tready,
    .in_tdata,
    .out_tvalid,
    .out_tready,
    .out_tdata,
    .out_tuser,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("height_plateau_qualifier_unit verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Same level when the absolute difference does not exceed the threshold.
  function automatic bit close_to(input int a, input int b);
    int gap;
    gap = (a >= b) ? a - b : b - a;
    return gap <= int'(model_threshold);
  endfunction

  // Advance the predicted state by one accepted sample; return 1 when an event
  // is due, with its fields in ev.
  function automatic bit advance_plateau_state(input hpq_pkg::sample_t s,
                                               output plateau_event_t ev);
    bit emit;
    emit     = 1'b0;
    ev.kind  = hpq_pkg::KIND_HEIGHT;
    ev.tag   = model_station;
    ev.value = s;
    // latch the very first sample as the belt baseline
    if (!have_baseline) begin
      belt_baseline = s;
      have_baseline = 1'b1;
    end
    if (close_to(int'(s), int'(belt_baseline))) begin
      // back on the belt: drop the candidate, close an open plateau
      candidate_armed = 1'b0;
      if (end_armed) begin
        ev.kind   = hpq_pkg::KIND_ENDED;
        emit      = 1'b1;
        end_armed = 1'b0;
      end
    end else if (close_to(int'(s), int'(plateau_level))) begin
      // on the confirmed level; before any confirmation the level is -1
      emit      = 1'b1;
      end_armed = 1'b1;
    end else if (!candidate_armed) begin
      candidate_armed = 1'b1;
      candidate       = s;
    end else if (close_to(int'(s), int'(candidate))) begin
      plateau_level   = hpq_pkg::level_t'(s);
      candidate_armed = 1'b0;
    end else begin
      // far second value: discard it along with the candidate
      candidate_armed = 1'b0;
    end
    return emit;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pattern and checking
  // ---------------------------------------------------------------------------

  // Drive out_tready; a long hold-off is counted here whenever a test asks.
  always @(posedge clk) begin : sink_ready
    int stall_served;
    int stall_left;
    if (stall_served != stall_requests) begin
      stall_served = stall_requests;
      stall_left   = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (int'($urandom_range(99)) >= sink_stall_pct);
    end
  end

  // Compare every accepted event with the oldest prediction.
  always @(posedge clk) begin : event_check
    plateau_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event kind=%0b tag=%0b height=%0d",
                 $time, out_tuser[0], out_tuser[1], out_tdata[11:0]);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        if (out_tuser[0] !== want.kind) begin
          $display("%0t: event_kind expected %0b actual %0b", $time, want.kind, out_tuser[0]);
          mismatch_count++;
        end
        if (out_tuser[1] !== want.tag) begin
          $display("%0t: station_tag expected %0b actual %0b", $time, want.tag, out_tuser[1]);
          mismatch_count++;
        end
        if (out_tdata[11:0] !== want.value) begin
          $display("%0t: height_value expected %0d actual %0d",
                   $time, want.value, out_tdata[11:0]);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------

  // Offer one sample, idling beforehand at the current gap rate; predict on acceptance.
  task automatic send_sample(input int value);
    plateau_event_t ev;
    while (int'($urandom_range(99)) < sender_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= hpq_pkg::tdata_t'(hpq_pkg::sample_t'(value));
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (advance_plateau_state(hpq_pkg::sample_t'(value), ev))
      pending_events.insert(pending_events.size(), ev);
  endtask

  // Write a register once the block has gone idle.
  task automatic write_register(input logic index, input int value);
    in_tvalid <= 1'b0;
    // wait for outstanding events, then for items that give none
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= hpq_pkg::cfg_data_t'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    if (index == hpq_pkg::REG_THRESHOLD)
      model_threshold = hpq_pkg::thresh_t'(value);
    else
      model_station = value[0];
  endtask

  // A sample that stays within threshold of every other sample drawn round centre.
  function automatic int near_level(input int centre);
    int half;
    int v;
    half = int'(model_threshold) / 2;
    v    = centre - half + int'($urandom_range(2 * half));
    return (v < 0) ? 0 : (v > MAX_SAMPLE) ? MAX_SAMPLE : v;
  endfunction

  // A level well clear of the baseline at the current threshold.
  function automatic int far_level();
    int lvl;
    int gap;
    do begin
      lvl = int'($urandom_range(MAX_SAMPLE));
      gap = (lvl >= int'(belt_baseline)) ? lvl - int'(belt_baseline) : int'(belt_baseline) - lvl;
    end while (gap <= 2 * int'(model_threshold) + 1);
    return lvl;
  endfunction

  // One burst of random stimulus: mostly whole plateaus, some broken ones and noise.
  task automatic send_episode();
    int lvl;
    int pick;
    lvl  = far_level();
    pick = int'($urandom_range(9));
    if (pick < 6) begin
      // belt, two samples to confirm, a run on the plateau, back to the belt
      repeat ($urandom_range(2)) send_sample(near_level(int'(belt_baseline)));
      repeat (2) send_sample(near_level(lvl));
      repeat ($urandom_range(1, 8)) send_sample(near_level(lvl));
      repeat ($urandom_range(1, 2)) send_sample(near_level(int'(belt_baseline)));
    end else if (pick < 8) begin
      // lone candidate, then either a far value or the belt
      send_sample(near_level(lvl));
      if ($urandom_range(1))
        send_sample(int'($urandom_range(MAX_SAMPLE)));
      else
        send_sample(near_level(int'(belt_baseline)));
    end else begin
      repeat ($urandom_range(1, 4)) send_sample(int'($urandom_range(MAX_SAMPLE)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: baseline capture, the unconfirmed level of -1, confirmation,
  // a far second value, plateau end and a quiet return to the belt.
  task automatic test_directed_plateaus();
    int seq[] = '{BELT_SAMPLE, 0, BELT_SAMPLE, 3000, 3010, 3030, MAX_SAMPLE,
                  100, 100, 120, BELT_SAMPLE, 2040};
    sender_gap_pct = 6;
    sink_stall_pct = 65;
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // Threshold at both ends and the second station.
  task automatic test_threshold_extremes();
    int exact[] = '{2001, 2001, 2001, BELT_SAMPLE, 0, MAX_SAMPLE, 2001};
    write_register(hpq_pkg::REG_THRESHOLD, 0);
    write_register(hpq_pkg::REG_STATION, 1);
    // exact matches only; sample 0 no longer matches any level
    foreach (exact[i]) send_sample(exact[i]);
    // every sample now sits on the baseline, closing the open plateau
    write_register(hpq_pkg::REG_THRESHOLD, MAX_SAMPLE);
    write_register(hpq_pkg::REG_STATION, 0);
    send_sample(MAX_SAMPLE);
    send_sample(0);
  endtask

  // Random plateaus under one idling pattern and a fresh random setting.
  task automatic test_random_plateaus(input int gap_pct, input int stall_pct, input int n);
    int target;
    sender_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    case ($urandom_range(3))
      0:       write_register(hpq_pkg::REG_THRESHOLD, 0);
      1:       write_register(hpq_pkg::REG_THRESHOLD, $urandom_range(1, 20));
      2:       write_register(hpq_pkg::REG_THRESHOLD, $urandom_range(21, 150));
      default: write_register(hpq_pkg::REG_THRESHOLD, $urandom_range(151, 400));
    endcase
    write_register(hpq_pkg::REG_STATION, $urandom_range(1));
    target = items_sent + n;
    while (items_sent < target) send_episode();
  endtask

  // Hold the receiver off for a long stretch while a plateau streams in, so the
  // result register fills and the input side stalls.
  task automatic test_output_stall();
    int lvl;
    sender_gap_pct = 0;
    sink_stall_pct = 0;
    write_register(hpq_pkg::REG_THRESHOLD, 30);
    lvl = far_level();
    stall_requests++;
    repeat (42) send_sample(near_level(lvl));
    send_sample(near_level(int'(belt_baseline)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_plateaus();
    test_threshold_extremes();
    test_random_plateaus(6, 65, 110);
    test_random_plateaus(6, 65, 110);
    test_random_plateaus(65, 6, 110);
    test_random_plateaus(65, 6, 110);
    test_random_plateaus(0, 0, 110);
    test_output_stall();
    test_random_plateaus(0, 0, 110);

    // drain: nothing outstanding, then let any stray event show itself
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples and checked %0d events over %0d register writes,",
             items_sent, events_checked, reg_writes);
    $display("covering thresholds 0 to 4095, both stations and a long output stall.");
    if (mismatch_count == 0) begin
      $display("height_plateau_qualifier_unit verification clean");
    end else begin
      $display("height_plateau_qualifier_unit verification failed");
    end
    $finish;
  end

endmodule
